// File: sv/xkdf_pkg.sv
// Shared constants and types for the XOR-keyed chunk deframer.
`default_nettype none

package xkdf_pkg;

  // Datapath widths.
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 24;
  localparam int HDR_CNT_W     = 2;
  localparam int POSITION_BITS = 32;
  localparam int REGION_W      = 32;

  // The header-fit compare needs one spare bit above the wider operand.
  localparam int CMP_W = ((POSITION_BITS > REGION_W) ? POSITION_BITS : REGION_W) + 1;

  // Number of bytes in a chunk header and the count value of the key byte.
  localparam int HEADER_BYTES = 4;
  localparam logic [HDR_CNT_W-1:0] HDR_KEY_SLOT = HDR_CNT_W'(HEADER_BYTES - 1);

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  // Register index, taken from the word address of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_LENGTH = 3'd0,
    REG_TAG_ENABLE    = 3'd1,
    REG_EXEC_KEY_A    = 3'd2,
    REG_EXEC_KEY_B    = 3'd3,
    REG_EXEC_KEY_C    = 3'd4
  } cfg_idx_t;

  // Deframer phase, one-hot.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_t;

endpackage

`default_nettype wire

// File: sv/xor_keyed_chunk_deframer.sv
// Top level of the XOR-keyed chunk deframer: config registers, input stage and result stage.
//
//   Channel   Ports                                  Direction  Width
//   input     in_valid, in_ready, in_byte            in         8
//   result    out_valid, out_ready, out_plain_byte,  out        8+8+24+1+1
//             out_chunk_key, out_chunk_length,
//             out_chunk_end, out_exec_chunk
//   config    psel, penable, pwrite, paddr, pwdata,  in/out     5 addr, 32 data
//             prdata, pready
//
// One byte is accepted per cycle unless a stall on out_ready holds it. A byte is held
// in the input register, decoded there against the deframer state, and a payload
// byte then moves on into the result register, which drives out_valid. Both registers
// advance together whenever the result register is empty or being drained, so a
// stall on out_ready backs up into in_ready with no bubbles.
// Reset (synchronous, active low) clears the valid flags, the state and the
// configuration. Once a header does not fit in the region the block drops every
// byte until reset.
`default_nettype none

module xor_keyed_chunk_deframer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input byte channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [xkdf_pkg::BYTE_W-1:0]      in_byte,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [xkdf_pkg::BYTE_W-1:0]           out_plain_byte,
  output logic [xkdf_pkg::BYTE_W-1:0]           out_chunk_key,
  output logic [xkdf_pkg::LEN_W-1:0]            out_chunk_length,
  output logic                                  out_chunk_end,
  output logic                                  out_exec_chunk,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [xkdf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [xkdf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [xkdf_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  // Configuration registers.
  logic [xkdf_pkg::REGION_W-1:0]        region_length_r;
  logic                                 tag_enable_r;
  logic [xkdf_pkg::BYTE_W-1:0]          exec_key_a_r;
  logic [xkdf_pkg::BYTE_W-1:0]          exec_key_b_r;
  logic [xkdf_pkg::BYTE_W-1:0]          exec_key_c_r;
  xkdf_pkg::cfg_idx_t                   cfg_idx;
  logic                                 cfg_wr;

  // Input stage.
  logic                                 s1_valid_r;
  logic [xkdf_pkg::BYTE_W-1:0]          s1_byte_r;
  logic                                 s1_adv;

  // Deframer state.
  xkdf_pkg::phase_t                     phase_r, phase_nxt;
  logic [xkdf_pkg::HDR_CNT_W-1:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [xkdf_pkg::LEN_W-1:0]           length_acc_r, length_acc_nxt;
  logic [xkdf_pkg::BYTE_W-1:0]          key_r, key_nxt;
  logic [xkdf_pkg::LEN_W-1:0]           payload_left_r, payload_left_nxt;
  logic [xkdf_pkg::POSITION_BITS-1:0]   position_r, position_nxt;
  logic                                 stopped_r, stopped_nxt;

  // Decode results.
  logic                                 emit;
  logic                                 hdr_no_fit;
  logic                                 key_match;
  logic [xkdf_pkg::LEN_W-1:0]           key_rep;
  logic [xkdf_pkg::LEN_W-1:0]           len_decoded;

  // Result register.
  logic                                 out_valid_r;
  logic [xkdf_pkg::BYTE_W-1:0]          out_plain_r;
  logic [xkdf_pkg::BYTE_W-1:0]          out_key_r;
  logic [xkdf_pkg::LEN_W-1:0]           out_len_r;
  logic                                 out_end_r;
  logic                                 out_exec_r;

  // Configuration writes complete in the access phase; reads are combinational.
  assign pready  = 1'b1;
  assign cfg_idx = xkdf_pkg::cfg_idx_t'(paddr[xkdf_pkg::CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_length_r <= '0;
      tag_enable_r    <= 1'b0;
      exec_key_a_r    <= '0;
      exec_key_b_r    <= '0;
      exec_key_c_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        xkdf_pkg::REG_REGION_LENGTH: region_length_r <= pwdata[xkdf_pkg::REGION_W-1:0];
        xkdf_pkg::REG_TAG_ENABLE:    tag_enable_r    <= pwdata[0];
        xkdf_pkg::REG_EXEC_KEY_A:    exec_key_a_r    <= pwdata[xkdf_pkg::BYTE_W-1:0];
        xkdf_pkg::REG_EXEC_KEY_B:    exec_key_b_r    <= pwdata[xkdf_pkg::BYTE_W-1:0];
        xkdf_pkg::REG_EXEC_KEY_C:    exec_key_c_r    <= pwdata[xkdf_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      xkdf_pkg::REG_REGION_LENGTH: prdata = xkdf_pkg::CFG_DATA_W'(region_length_r);
      xkdf_pkg::REG_TAG_ENABLE:    prdata = xkdf_pkg::CFG_DATA_W'(tag_enable_r);
      xkdf_pkg::REG_EXEC_KEY_A:    prdata = xkdf_pkg::CFG_DATA_W'(exec_key_a_r);
      xkdf_pkg::REG_EXEC_KEY_B:    prdata = xkdf_pkg::CFG_DATA_W'(exec_key_b_r);
      xkdf_pkg::REG_EXEC_KEY_C:    prdata = xkdf_pkg::CFG_DATA_W'(exec_key_c_r);
      default:                     prdata = '0;
    endcase
  end

  // Both stages move together whenever the result register can take a new value.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
  end

  // A new header must fit all four of its bytes inside the region.
  assign hdr_no_fit = (xkdf_pkg::CMP_W'(position_r) + xkdf_pkg::CMP_W'(xkdf_pkg::HEADER_BYTES))
                      > xkdf_pkg::CMP_W'(region_length_r);

  // The key is applied to all three length bytes at once.
  assign key_rep     = {s1_byte_r, s1_byte_r, s1_byte_r};
  assign len_decoded = length_acc_r ^ key_rep;

  assign key_match = tag_enable_r &&
                     ((key_r == exec_key_a_r) || (key_r == exec_key_b_r) ||
                      (key_r == exec_key_c_r));

  // Per-byte decode of the held byte against the current state.
  always_comb begin
    phase_nxt        = phase_r;
    hdr_cnt_nxt      = hdr_cnt_r;
    length_acc_nxt   = length_acc_r;
    key_nxt          = key_r;
    payload_left_nxt = payload_left_r;
    position_nxt     = position_r;
    stopped_nxt      = stopped_r;
    emit             = 1'b0;
    if (s1_valid_r && s1_adv && !stopped_r) begin
      unique case (phase_r)
        xkdf_pkg::PH_PAYLOAD: begin
          emit             = 1'b1;
          position_nxt     = position_r + xkdf_pkg::POSITION_BITS'(1);
          payload_left_nxt = payload_left_r - xkdf_pkg::LEN_W'(1);
          if (payload_left_r == xkdf_pkg::LEN_W'(1)) begin
            phase_nxt   = xkdf_pkg::PH_HEADER;
            hdr_cnt_nxt = '0;
          end
        end
        xkdf_pkg::PH_HEADER: begin
          if ((hdr_cnt_r == '0) && hdr_no_fit) begin
            stopped_nxt = 1'b1;
          end else begin
            position_nxt = position_r + xkdf_pkg::POSITION_BITS'(1);
            if (hdr_cnt_r == xkdf_pkg::HDR_KEY_SLOT) begin
              // Key byte closes the header; a zero length skips the chunk.
              key_nxt        = s1_byte_r;
              length_acc_nxt = len_decoded;
              hdr_cnt_nxt    = '0;
              if (len_decoded != '0) begin
                payload_left_nxt = len_decoded;
                phase_nxt        = xkdf_pkg::PH_PAYLOAD;
              end
            end else begin
              hdr_cnt_nxt = hdr_cnt_r + xkdf_pkg::HDR_CNT_W'(1);
              unique case (hdr_cnt_r)
                2'd0:    length_acc_nxt = {16'h0000, s1_byte_r};
                2'd1:    length_acc_nxt = {length_acc_r[23:16], s1_byte_r, length_acc_r[7:0]};
                default: length_acc_nxt = {s1_byte_r, length_acc_r[15:0]};
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= xkdf_pkg::PH_HEADER;
      hdr_cnt_r      <= '0;
      length_acc_r   <= '0;
      key_r          <= '0;
      payload_left_r <= '0;
      position_r     <= '0;
      stopped_r      <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      hdr_cnt_r      <= hdr_cnt_nxt;
      length_acc_r   <= length_acc_nxt;
      key_r          <= key_nxt;
      payload_left_r <= payload_left_nxt;
      position_r     <= position_nxt;
      stopped_r      <= stopped_nxt;
    end
  end

  // Result register: loads a decoded payload byte or empties when drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_plain_r <= s1_byte_r ^ key_r;
      out_key_r   <= key_r;
      out_len_r   <= length_acc_r;
      out_end_r   <= (payload_left_r == xkdf_pkg::LEN_W'(1));
      out_exec_r  <= key_match;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_plain_byte   = out_plain_r;
  assign out_chunk_key    = out_key_r;
  assign out_chunk_length = out_len_r;
  assign out_chunk_end    = out_end_r;
  assign out_exec_chunk   = out_exec_r;

endmodule

`default_nettype wire

// File: bench/xor_keyed_chunk_deframer_tb.sv
// Self-checking testbench for the XOR-keyed chunk deframer.
`timescale 1ns / 1ps

module xor_keyed_chunk_deframer_tb;

  // Decoded payload byte as it should leave the result channel.
  typedef struct packed {
    logic [xkdf_pkg::BYTE_W-1:0] plain_byte;
    logic [xkdf_pkg::BYTE_W-1:0] chunk_key;
    logic [xkdf_pkg::LEN_W-1:0]  chunk_length;
    logic                        chunk_end;
    logic                        exec_chunk;
  } plain_beat_t;

  // How the region length is set for a phase of traffic.
  typedef enum {
    RGN_OPEN,         // largest value, every header fits
    RGN_TIGHT,        // ends exactly where the phase's bytes end, plus one header
    RGN_HEADER_ONLY,  // room for exactly one more header
    RGN_CLOSED        // zero
  } region_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [xkdf_pkg::BYTE_W-1:0]     in_byte = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [xkdf_pkg::BYTE_W-1:0]     out_plain_byte;
  logic [xkdf_pkg::BYTE_W-1:0]     out_chunk_key;
  logic [xkdf_pkg::LEN_W-1:0]      out_chunk_length;
  logic                            out_chunk_end;
  logic                            out_exec_chunk;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [xkdf_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [xkdf_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [xkdf_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  // Raw bytes waiting for the driver, bytes of the phase being built, and the
  // tail of a chunk that spills into the next phase.
  logic [xkdf_pkg::BYTE_W-1:0] byte_queue[$];
  logic [xkdf_pkg::BYTE_W-1:0] phase_bytes[$];
  logic [xkdf_pkg::BYTE_W-1:0] carry_bytes[$];
  plain_beat_t                 expected_plain[$];
  plain_beat_t                 want;
  int unsigned                 mismatches = 0;

  // Turn off random idling on either side.
  logic steady_in = 1'b0;
  logic steady_out = 1'b0;

  // Register values planned for the next phase.
  logic                        plan_tag;
  logic [xkdf_pkg::BYTE_W-1:0] plan_key_a;
  logic [xkdf_pkg::BYTE_W-1:0] plan_key_b;
  logic [xkdf_pkg::BYTE_W-1:0] plan_key_c;

  // Mirror of the configuration registers.
  logic [xkdf_pkg::REGION_W-1:0] m_region = '0;
  logic                          m_tag = 1'b0;
  logic [xkdf_pkg::BYTE_W-1:0]   m_key_a = '0;
  logic [xkdf_pkg::BYTE_W-1:0]   m_key_b = '0;
  logic [xkdf_pkg::BYTE_W-1:0]   m_key_c = '0;

  // Mirror of the deframer state.
  xkdf_pkg::phase_t                   st_phase = xkdf_pkg::PH_HEADER;
  logic [xkdf_pkg::HDR_CNT_W-1:0]     st_hdr_cnt = '0;
  logic [xkdf_pkg::LEN_W-1:0]         st_len = '0;
  logic [xkdf_pkg::BYTE_W-1:0]        st_key = '0;
  logic [xkdf_pkg::LEN_W-1:0]         st_left = '0;
  logic [xkdf_pkg::POSITION_BITS-1:0] st_pos = '0;
  logic                               st_halted = 1'b0;

  xor_keyed_chunk_deframer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_plain_byte   (out_plain_byte),
    .out_chunk_key    (out_chunk_key),
    .out_chunk_length (out_chunk_length),
    .out_chunk_end    (out_chunk_end),
    .out_exec_chunk   (out_exec_chunk),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the mirrored deframer by one raw byte and queue any decoded byte.
  function automatic void decode_byte(input logic [xkdf_pkg::BYTE_W-1:0] b);
    plain_beat_t beat;
    if (st_halted) return;
    if (st_phase == xkdf_pkg::PH_PAYLOAD) begin
      beat.plain_byte   = b ^ st_key;
      beat.chunk_key    = st_key;
      beat.chunk_length = st_len;
      beat.chunk_end    = (st_left == xkdf_pkg::LEN_W'(1));
      beat.exec_chunk   = m_tag && (st_key == m_key_a || st_key == m_key_b ||
                                    st_key == m_key_c);
      expected_plain.push_back(beat);
      st_pos  = st_pos + 1'b1;
      st_left = st_left - 1'b1;
      if (st_left == '0) begin
        st_phase   = xkdf_pkg::PH_HEADER;
        st_hdr_cnt = '0;
      end
      return;
    end
    // A header may only start where all of its bytes fit in the region.
    if (st_hdr_cnt == '0) begin
      if (({1'b0, st_pos} + 33'(xkdf_pkg::HEADER_BYTES)) > {1'b0, m_region}) begin
        st_halted = 1'b1;
        return;
      end
      st_len = '0;
    end
    st_pos = st_pos + 1'b1;
    if (st_hdr_cnt < xkdf_pkg::HDR_KEY_SLOT) begin
      st_len     = st_len | (xkdf_pkg::LEN_W'(b) << (8 * st_hdr_cnt));
      st_hdr_cnt = st_hdr_cnt + 1'b1;
      return;
    end
    // Key byte: unmask the length; a zero length skips the chunk.
    st_key     = b;
    st_len     = st_len ^ {b, b, b};
    st_hdr_cnt = '0;
    if (st_len != '0) begin
      st_left  = st_len;
      st_phase = xkdf_pkg::PH_PAYLOAD;
    end
  endfunction

  // Header of a chunk: length bytes masked with the key, low byte first.
  function automatic void add_header(input logic [xkdf_pkg::BYTE_W-1:0] key,
                                     input logic [xkdf_pkg::LEN_W-1:0] length);
    logic [xkdf_pkg::LEN_W-1:0] raw;
    raw = length ^ {key, key, key};
    phase_bytes.push_back(raw[7:0]);
    phase_bytes.push_back(raw[15:8]);
    phase_bytes.push_back(raw[23:16]);
    phase_bytes.push_back(key);
  endfunction

  function automatic void add_chunk(input logic [xkdf_pkg::BYTE_W-1:0] key,
                                    input logic [xkdf_pkg::LEN_W-1:0] length);
    add_header(key, length);
    repeat (length) phase_bytes.push_back(xkdf_pkg::BYTE_W'($urandom));
  endfunction

  // Mostly short chunks, some empty ones, keys often matching a marked key.
  function automatic void add_random_chunk();
    logic [xkdf_pkg::BYTE_W-1:0] key;
    int unsigned                 pick;
    int unsigned                 length;
    pick = $urandom_range(99);
    if (pick < 12) key = plan_key_a;
    else if (pick < 24) key = plan_key_b;
    else if (pick < 35) key = plan_key_c;
    else key = xkdf_pkg::BYTE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) length = 0;
    else if (pick < 75) length = $urandom_range(1, 8);
    else if (pick < 95) length = $urandom_range(9, 40);
    else length = $urandom_range(41, 255);
    add_chunk(key, xkdf_pkg::LEN_W'(length));
  endfunction

  function automatic logic [xkdf_pkg::BYTE_W-1:0] random_key();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    return xkdf_pkg::BYTE_W'($urandom);
  endfunction

  function automatic void plan_config();
    plan_tag   = ($urandom_range(99) < 70);
    plan_key_a = random_key();
    plan_key_b = random_key();
    plan_key_c = ($urandom_range(9) == 0) ? plan_key_a : random_key();
  endfunction

  // Fill a phase with random chunks; when split, the chunk that crosses the
  // target size is finished in the next phase.
  function automatic void build_random(input int unsigned target, input bit split);
    phase_bytes = carry_bytes;
    carry_bytes.delete();
    while (phase_bytes.size() < target) add_random_chunk();
    if (split) begin
      while (phase_bytes.size() > target) carry_bytes.push_front(phase_bytes.pop_back());
    end
  endfunction

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input xkdf_pkg::cfg_idx_t idx,
                           input logic [xkdf_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= xkdf_pkg::CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      xkdf_pkg::REG_REGION_LENGTH: m_region = value;
      xkdf_pkg::REG_TAG_ENABLE:    m_tag    = value[0];
      xkdf_pkg::REG_EXEC_KEY_A:    m_key_a  = value[xkdf_pkg::BYTE_W-1:0];
      xkdf_pkg::REG_EXEC_KEY_B:    m_key_b  = value[xkdf_pkg::BYTE_W-1:0];
      xkdf_pkg::REG_EXEC_KEY_C:    m_key_c  = value[xkdf_pkg::BYTE_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every byte is taken and every decoded byte has come out, then
  // let header bytes still in the pipeline settle.
  task automatic wait_idle();
    @(posedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_plain.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reprogram the block while idle, then release the phase's bytes to the driver.
  task automatic start_phase(input region_kind_t kind, input bit steady);
    logic [xkdf_pkg::REGION_W-1:0] region;
    wait_idle();
    case (kind)
      RGN_OPEN:        region = '1;
      RGN_TIGHT:       region = st_pos + xkdf_pkg::REGION_W'(phase_bytes.size()) +
                                xkdf_pkg::REGION_W'(xkdf_pkg::HEADER_BYTES);
      RGN_HEADER_ONLY: region = st_pos + xkdf_pkg::REGION_W'(xkdf_pkg::HEADER_BYTES);
      default:         region = '0;
    endcase
    write_reg(xkdf_pkg::REG_REGION_LENGTH, region);
    write_reg(xkdf_pkg::REG_TAG_ENABLE, xkdf_pkg::CFG_DATA_W'(plan_tag));
    write_reg(xkdf_pkg::REG_EXEC_KEY_A, xkdf_pkg::CFG_DATA_W'(plan_key_a));
    write_reg(xkdf_pkg::REG_EXEC_KEY_B, xkdf_pkg::CFG_DATA_W'(plan_key_b));
    write_reg(xkdf_pkg::REG_EXEC_KEY_C, xkdf_pkg::CFG_DATA_W'(plan_key_c));
    steady_in  = steady;
    steady_out = steady;
    foreach (phase_bytes[i]) byte_queue.push_back(phase_bytes[i]);
    phase_bytes.delete();
  endtask

  // Input driver: predicts each accepted transaction, then offers the next byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte);
      if (!in_valid || in_ready) begin
        if (byte_queue.size() != 0 && (steady_in || $urandom_range(99) >= 26)) begin
          in_valid <= 1'b1;
          in_byte  <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void note_mismatch(input string field, input logic [31:0] expected_val,
                                        input logic [31:0] actual_val);
    mismatches++;
    $display("%0t: %s expected %0h actual %0h", $time, field, expected_val, actual_val);
  endfunction

  // Result monitor: compares each transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_plain.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, plain_byte %0h key %0h", $time, out_plain_byte,
                   out_chunk_key);
        end else begin
          want = expected_plain.pop_front();
          if (out_plain_byte !== want.plain_byte)
            note_mismatch("plain_byte", want.plain_byte, out_plain_byte);
          if (out_chunk_key !== want.chunk_key)
            note_mismatch("chunk_key", want.chunk_key, out_chunk_key);
          if (out_chunk_length !== want.chunk_length)
            note_mismatch("chunk_length", want.chunk_length, out_chunk_length);
          if (out_chunk_end !== want.chunk_end)
            note_mismatch("chunk_end", want.chunk_end, out_chunk_end);
          if (out_exec_chunk !== want.exec_chunk)
            note_mismatch("exec_chunk", want.exec_chunk, out_exec_chunk);
        end
      end
      out_ready <= steady_out || ($urandom_range(99) >= 26);
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: marked keys at both extremes, payload extremes, an empty chunk,
    // a last byte in every chunk and an unmarked key.
    plan_tag   = 1'b1;
    plan_key_a = 8'h00;
    plan_key_b = 8'hFF;
    plan_key_c = 8'h5A;
    add_header(8'h00, 24'd1);
    phase_bytes.push_back(8'h00);
    add_header(8'hFF, 24'd2);
    phase_bytes.push_back(8'hFF);
    phase_bytes.push_back(8'h00);
    add_header(8'h37, 24'd0);
    add_header(8'h5A, 24'd3);
    phase_bytes.push_back(8'h5A);
    phase_bytes.push_back(8'hA5);
    phase_bytes.push_back(8'hFF);
    add_header(8'h81, 24'd1);
    phase_bytes.push_back(8'h7E);
    start_phase(RGN_OPEN, 1'b0);

    // Same marked key with tagging off, region ending one header after the traffic.
    plan_tag = 1'b0;
    add_header(8'hFF, 24'd2);
    phase_bytes.push_back(8'hFF);
    phase_bytes.push_back(8'h00);
    start_phase(RGN_TIGHT, 1'b0);

    // One chunk longer than a byte can count so that the middle length byte is used.
    plan_config();
    add_chunk(xkdf_pkg::BYTE_W'($urandom), 24'h000104);
    start_phase(RGN_TIGHT, 1'b0);

    // Random chunks over several settings; all but the last phase end inside a chunk.
    for (int p = 0; p < 5; p++) begin
      plan_config();
      build_random(190, p < 4);
      start_phase(($urandom_range(1) != 0) ? RGN_OPEN : RGN_TIGHT, p == 2);
    end

    // Header that fits exactly, payload decoded past the region end, then the
    // next header does not fit and every later byte is dropped.
    plan_config();
    plan_tag = 1'b1;
    add_chunk(plan_key_b, 24'd3);
    repeat (5) phase_bytes.push_back(xkdf_pkg::BYTE_W'($urandom));
    start_phase(RGN_HEADER_ONLY, 1'b0);

    // Empty region while halted; these bytes must vanish as well.
    repeat (2) phase_bytes.push_back(xkdf_pkg::BYTE_W'($urandom));
    start_phase(RGN_CLOSED, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
sv/xkdf_pkg.sv
sv/xor_keyed_chunk_deframer.sv
bench/xor_keyed_chunk_deframer_tb.sv
